FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/gbn_pkg.sv
// ---------------------------------------------------------------------------
// gbn_pkg
// Types and constants of the go-back-N sender window controller.
// ---------------------------------------------------------------------------
package gbn_pkg;

   // Sequence space and window
   localparam int SEQ_NUMBERS = 20;
   localparam int WINDOW      = 10;
   localparam int SEQ_W       = $clog2(SEQ_NUMBERS);

   // Field widths
   localparam int COUNT_W   = 16;
   localparam int POLL_W    = 8;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // Register reset values
   localparam logic [COUNT_W-1:0] TOTAL_RESET   = '0;
   localparam logic [POLL_W-1:0]  TIMEOUT_RESET = POLL_W'(20);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_POLLS = CSR_IDX_W'(1);

   // Commands
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_SEND  = 2'd1,
      CMD_ACK   = 2'd2,
      CMD_POLL  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           command;
      logic [BYTE_W-1:0] ack_byte;
   } req_type;

   typedef struct packed {
      logic               send_grant;
      logic [4:0]         frame_seq;
      logic [COUNT_W-1:0] packet_index;
      logic               timed_out;
      logic               transfer_done;
      logic [4:0]         window_base;
   } rsp_type;

   // Configuration seen by the window logic
   typedef struct packed {
      logic [COUNT_W-1:0] total_packets;
      logic [POLL_W-1:0]  timeout_polls;
   } cfg_type;

endpackage

FILE: sv/gbn_csr.sv
// ---------------------------------------------------------------------------
// gbn_csr
// Configuration registers: packet total and poll timeout.
// ---------------------------------------------------------------------------
module gbn_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [gbn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gbn_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output gbn_pkg::cfg_type                cfg
);
   import gbn_pkg::*;

   logic [COUNT_W-1:0] total_ff, total_in;
   logic [POLL_W-1:0]  timeout_ff, timeout_in;

   // Decode register writes
   always_comb begin
      total_in   = total_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TOTAL_PACKETS: total_in   = csr_wdata[COUNT_W-1:0];
            CSR_TIMEOUT_POLLS: timeout_in = csr_wdata[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= TOTAL_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         total_ff   <= total_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg.total_packets = total_ff;
   assign cfg.timeout_polls = timeout_ff;

endmodule

FILE: sv/gbn_window.sv
// ---------------------------------------------------------------------------
// gbn_window
// Window state and single-pass step logic: start, send, ack, poll, done check.
// ---------------------------------------------------------------------------
module gbn_window (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  gbn_pkg::req_type  req,
   input  gbn_pkg::cfg_type  cfg,
   output gbn_pkg::rsp_type  rsp
);
   import gbn_pkg::*;

   logic [SEQ_NUMBERS-1:0] acked_ff, acked_in;
   logic [SEQ_W-1:0]       next_seq_ff, next_seq_in;
   logic [SEQ_W-1:0]       base_seq_ff, base_seq_in;
   logic [COUNT_W-1:0]     sent_ff, sent_in, sent_pre;
   logic [POLL_W-1:0]      polls_ff, polls_in;

   logic [SEQ_W:0]         outst_wide;
   logic [SEQ_W-1:0]       outstanding;
   logic [BYTE_W-1:0]      ack_idx;
   logic [SEQ_W-1:0]       idx;
   logic                   ack_ok;
   logic [POLL_W:0]        poll_cnt;
   logic [SEQ_W:0]         win_off;

   // Distance from base to next, modulo the sequence space
   always_comb begin
      if (next_seq_ff >= base_seq_ff) begin
         outst_wide = {1'b0, next_seq_ff} - {1'b0, base_seq_ff};
      end else begin
         outst_wide = {1'b0, next_seq_ff} + (SEQ_W+1)'(SEQ_NUMBERS) - {1'b0, base_seq_ff};
      end
      outstanding = outst_wide[SEQ_W-1:0];
   end

   assign ack_idx  = req.ack_byte - BYTE_W'(1);
   assign idx      = ack_idx[SEQ_W-1:0];
   assign ack_ok   = (req.ack_byte != '0) && (req.ack_byte <= BYTE_W'(SEQ_NUMBERS));
   assign poll_cnt = {1'b0, polls_ff} + (POLL_W+1)'(1);

   // Apply one command, then check for completion
   always_comb begin
      acked_in    = acked_ff;
      next_seq_in = next_seq_ff;
      base_seq_in = base_seq_ff;
      sent_pre    = sent_ff;
      polls_in    = polls_ff;
      win_off     = '0;
      rsp         = '0;

      case (req.command)
         CMD_START: begin
            acked_in    = '1;
            next_seq_in = '0;
            base_seq_in = '0;
            sent_pre    = '0;
            polls_in    = '0;
         end
         CMD_SEND: begin
            if (outstanding < SEQ_W'(WINDOW) && acked_ff[next_seq_ff] &&
                sent_ff < cfg.total_packets) begin
               rsp.send_grant            = 1'b1;
               rsp.frame_seq             = 5'(next_seq_ff + SEQ_W'(1));
               rsp.packet_index          = sent_ff;
               acked_in[next_seq_ff]     = 1'b0;
               next_seq_in = (next_seq_ff == SEQ_W'(SEQ_NUMBERS-1)) ? '0
                                                          : next_seq_ff + SEQ_W'(1);
               sent_pre    = sent_ff + COUNT_W'(1);
            end
         end
         CMD_ACK: begin
            polls_in = '0;
            if (ack_ok) begin
               if (base_seq_ff <= idx) begin
                  // mark base..idx acknowledged
                  for (int j = 0; j < SEQ_NUMBERS; j++) begin
                     if (SEQ_W'(j) >= base_seq_ff && SEQ_W'(j) <= idx) begin
                        acked_in[j] = 1'b1;
                     end
                  end
                  base_seq_in = (idx == SEQ_W'(SEQ_NUMBERS-1)) ? '0 : idx + SEQ_W'(1);
               end else if (!acked_ff[idx]) begin
                  // wrapped ack: mark base..end and 0..idx
                  for (int j = 0; j < SEQ_NUMBERS; j++) begin
                     if (SEQ_W'(j) >= base_seq_ff || SEQ_W'(j) <= idx) begin
                        acked_in[j] = 1'b1;
                     end
                  end
                  base_seq_in = idx + SEQ_W'(1);
               end
            end
         end
         CMD_POLL: begin
            if (poll_cnt > {1'b0, cfg.timeout_polls}) begin
               // go back: reopen the window and rewind to base
               polls_in = '0;
               for (int j = 0; j < SEQ_NUMBERS; j++) begin
                  if (SEQ_W'(j) >= base_seq_ff) begin
                     win_off = (SEQ_W+1)'(j) - {1'b0, base_seq_ff};
                  end else begin
                     win_off = (SEQ_W+1)'(j + SEQ_NUMBERS) - {1'b0, base_seq_ff};
                  end
                  if (win_off < (SEQ_W+1)'(WINDOW)) begin
                     acked_in[j] = 1'b1;
                  end
               end
               sent_pre    = (sent_ff >= COUNT_W'(outstanding))
                             ? sent_ff - COUNT_W'(outstanding) : '0;
               next_seq_in = base_seq_ff;
               rsp.timed_out = 1'b1;
            end else begin
               polls_in = poll_cnt[POLL_W-1:0];
            end
         end
         default: ;
      endcase

      // Completion: everything sent and acknowledged
      sent_in = sent_pre;
      if (sent_pre == cfg.total_packets && (&acked_in)) begin
         rsp.transfer_done = 1'b1;
         sent_in           = '0;
      end
      rsp.window_base = 5'(base_seq_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acked_ff    <= '1;
         next_seq_ff <= '0;
         base_seq_ff <= '0;
         sent_ff     <= '0;
         polls_ff    <= '0;
      end else if (step_en) begin
         acked_ff    <= acked_in;
         next_seq_ff <= next_seq_in;
         base_seq_ff <= base_seq_in;
         sent_ff     <= sent_in;
         polls_ff    <= polls_in;
      end
   end

endmodule

FILE: sv/go_back_n_sender_window.sv
// ---------------------------------------------------------------------------
// go_back_n_sender_window
// Go-back-N sender window controller with registered request and response.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_stall/req_payload (command, ack_byte);
//   one response per request leaves on rsp_valid/rsp_stall/rsp_payload.
//   A request is taken at an edge with valid high and stall low.
//   The csr_ port writes total_packets (index 0) and timeout_polls (index 1);
//   write it only while no request is in flight.
//   A taken request waits in the request register; its step result is then
//   loaded into the response register, which drives rsp_valid/rsp_payload.
//   Throughput: one request per cycle unless rsp_stall holds the response;
//   the whole step (bitmap masks over the twenty sequence entries, counters,
//   completion check) is one pass of logic between the two registers.
//   Reset (synchronous) marks every entry acknowledged, clears the window
//   and counters, loads total_packets 0 and timeout_polls 20.
//   When rsp_stall is high the response holds; the request register still
//   takes one more request, then req_stall rises until the response drains.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module go_back_n_sender_window (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gbn_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gbn_pkg::rsp_type                rsp_payload,
   input  logic                            csr_we,
   input  logic [gbn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gbn_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import gbn_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_ff, in_in;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_ff, out_in;
   logic     step_en;
   logic     req_take;
   cfg_type  cfg;
   rsp_type  step_rsp;

   gbn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gbn_window u_window (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (in_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // Advance when a request is held and the response register is free
   assign step_en   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_en;
   assign req_take  = req_valid && !req_stall;

   // Request register: load on take, drop once processed
   always_comb begin
      in_in       = req_take ? req_payload : in_ff;
      in_valid_in = req_take || (in_valid_ff && !step_en);
   end

   // Response register: load on step, drop once taken
   always_comb begin
      out_in       = step_en ? step_rsp : out_ff;
      out_valid_in = step_en || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // A response appears only after a processed request
   `ASSERT_IMPLIES(a_rsp_from_step, clock, reset, $rose(rsp_valid), $past(step_en))
   // A held request is neither lost nor altered while it waits
   `ASSERT_NEXT(a_req_hold, clock, reset, in_valid_ff && !step_en,
                in_valid_ff && $stable(in_ff))
   // A stalled response stays valid
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // No frame number without a grant
   `ASSERT_IMPLIES(a_seq_grant, clock, reset, rsp_valid && !rsp_payload.send_grant,
                   rsp_payload.frame_seq == 5'd0)

endmodule

FILE: tb/tb_go_back_n_sender_window.sv
// ---------------------------------------------------------------------------
// tb_go_back_n_sender_window
// Self-checking bench for the go-back-N sender window controller. A model
// of the window (ack bitmap, base, next sequence, sent and poll counters)
// predicts one response per accepted request. Responses are checked in
// order against it while both sides stall at random. Directed runs hit
// the register extremes, ignored ack bytes, window exhaustion, rewinds and
// completion. Random phases mix sends, well-formed acks, noise, polls, starts.
// ---------------------------------------------------------------------------
module tb_go_back_n_sender_window;
   timeunit 1ns;
   timeprecision 1ps;

   import gbn_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int MAX_REPORTS    = 10;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CSR_DAT_W-1:0] csr_wdata   = '0;

   // Window model state and its copy of the registers
   logic [SEQ_NUMBERS-1:0] ack_map     = '1;
   int unsigned            next_seq_q  = 0;
   int unsigned            base_seq_q  = 0;
   int unsigned            sent_q      = 0;
   int unsigned            polls_q     = 0;
   int unsigned            total_cfg   = 0;
   int unsigned            timeout_cfg = 20;

   rsp_type rsp_due[$];
   int      fail_count  = 0;
   int      idle_cycles = 0;
   bit      req_gaps_on = 1'b1;
   bit      rsp_gaps_on = 1'b1;
   int      hold_len    = 0;

   go_back_n_sender_window DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Advance the window model by one request and return its response
   function automatic rsp_type window_step(req_type r);
      rsp_type     o;
      int unsigned outs;
      int unsigned idx;
      int unsigned cnt;
      o    = '0;
      outs = (next_seq_q + SEQ_NUMBERS - base_seq_q) % SEQ_NUMBERS;
      case (r.command)
         CMD_START: begin
            ack_map    = '1;
            next_seq_q = 0;
            base_seq_q = 0;
            sent_q     = 0;
            polls_q    = 0;
         end
         CMD_SEND: begin
            if (outs < WINDOW && ack_map[next_seq_q] && sent_q < total_cfg) begin
               o.send_grant   = 1'b1;
               o.frame_seq    = 5'(next_seq_q + 1);
               o.packet_index = 16'(sent_q);
               ack_map[next_seq_q] = 1'b0;
               next_seq_q = (next_seq_q + 1) % SEQ_NUMBERS;
               sent_q     = (sent_q + 1) & 16'hFFFF;
            end
         end
         CMD_ACK: begin
            polls_q = 0;
            if (r.ack_byte >= 1 && r.ack_byte <= SEQ_NUMBERS) begin
               idx = r.ack_byte - 1;
               if (base_seq_q <= idx) begin
                  for (int k = base_seq_q; k <= idx; k++) ack_map[k] = 1'b1;
                  base_seq_q = (idx + 1) % SEQ_NUMBERS;
               end else if (!ack_map[idx]) begin
                  // cumulative ack that wraps past the end of the space
                  for (int k = base_seq_q; k < SEQ_NUMBERS; k++) ack_map[k] = 1'b1;
                  for (int k = 0; k <= idx; k++) ack_map[k] = 1'b1;
                  base_seq_q = idx + 1;
               end
            end
         end
         default: begin
            cnt = polls_q + 1;
            if (cnt > timeout_cfg) begin
               // go back to the base and reopen the whole window
               polls_q = 0;
               for (int k = 0; k < WINDOW; k++) ack_map[(base_seq_q + k) % SEQ_NUMBERS] = 1'b1;
               sent_q      = (sent_q >= outs) ? sent_q - outs : 0;
               next_seq_q  = base_seq_q;
               o.timed_out = 1'b1;
            end else begin
               polls_q = cnt;
            end
         end
      endcase
      if (sent_q == total_cfg && &ack_map) begin
         o.transfer_done = 1'b1;
         sent_q = 0;
      end
      o.window_base = 5'(base_seq_q);
      return o;
   endfunction

   // Offer one request, hold it until taken, then queue its response
   task automatic send_request(input cmd_type cmd, input logic [7:0] abyte);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{command: cmd, ack_byte: abyte};
      do @(posedge clock); while (req_stall);
      rsp_due.push_back(window_step('{command: cmd, ack_byte: abyte}));
   endtask

   // Drop valid and wait until every queued response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers; call only while the block is idle
   task automatic configure(input int unsigned total, input int unsigned tmo);
      csr_we    <= 1'b1;
      csr_index <= CSR_TOTAL_PACKETS;
      csr_wdata <= CSR_DAT_W'(total);
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_POLLS;
      csr_wdata <= CSR_DAT_W'(tmo & 8'hFF);
      @(posedge clock);
      csr_we      <= 1'b0;
      total_cfg   = total & 16'hFFFF;
      timeout_cfg = tmo & 8'hFF;
   endtask

   // Pick an ack byte that covers part of what is outstanding, or any valid one if nothing is
   function automatic logic [7:0] good_ack_byte();
      int unsigned outs;
      outs = (next_seq_q + SEQ_NUMBERS - base_seq_q) % SEQ_NUMBERS;
      if (outs == 0) return 8'($urandom_range(1, SEQ_NUMBERS));
      return 8'((base_seq_q + $urandom_range(0, outs - 1)) % SEQ_NUMBERS + 1);
   endfunction

   // Send one random request, mostly well formed
   task automatic send_random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      send_request(CMD_SEND, 8'($urandom));
      else if (pick < 75) send_request(CMD_ACK, good_ack_byte());
      else if (pick < 83) send_request(CMD_ACK, 8'($urandom_range(0, 255)));
      else if (pick < 97) send_request(CMD_POLL, 8'($urandom));
      else                send_request(CMD_START, 8'($urandom));
   endtask

   task automatic test_reset_state();
      // registers at reset values: no packets, so every step reports done
      send_request(CMD_SEND, 8'h00);
      send_request(CMD_POLL, 8'hFF);
      send_request(CMD_ACK, 8'd1);
      send_request(CMD_START, 8'h00);
   endtask

   task automatic test_window_limits();
      drain_responses();
      configure(12, 1);
      send_request(CMD_START, 8'h00);
      repeat (11) send_request(CMD_SEND, 8'h00);
      // out-of-range ack bytes leave the window alone
      send_request(CMD_ACK, 8'd0);
      send_request(CMD_ACK, 8'd255);
      send_request(CMD_ACK, 8'(SEQ_NUMBERS + 1));
      send_request(CMD_ACK, 8'd3);
      send_request(CMD_POLL, 8'h00);
      send_request(CMD_POLL, 8'h00);
      send_request(CMD_SEND, 8'h00);
      send_request(CMD_ACK, 8'(SEQ_NUMBERS));
   endtask

   task automatic test_zero_timeout();
      drain_responses();
      configure(16'hFFFF, 0);
      send_request(CMD_START, 8'h00);
      send_request(CMD_SEND, 8'h00);
      send_request(CMD_SEND, 8'h00);
      send_request(CMD_POLL, 8'h00);
      send_request(CMD_POLL, 8'h00);
   endtask

   task automatic test_long_timeout();
      drain_responses();
      configure(8, 255);
      send_request(CMD_START, 8'h00);
      repeat (5) send_request(CMD_SEND, 8'h00);
      repeat (260) send_request(CMD_POLL, 8'h00);
   endtask

   task automatic test_backpressure();
      drain_responses();
      configure(30, 4);
      req_gaps_on = 1'b0;
      hold_len    = 200;
      send_request(CMD_START, 8'h00);
      repeat (40) send_random_request();
      req_gaps_on = 1'b1;
   endtask

   // One random phase; the sender pauses for a full drain halfway through
   task automatic test_random_phase(input int n, input int unsigned total,
                                    input int unsigned tmo, input bit req_gaps,
                                    input bit rsp_gaps);
      drain_responses();
      configure(total, tmo);
      req_gaps_on = req_gaps;
      rsp_gaps_on = rsp_gaps;
      send_request(CMD_START, 8'h00);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) drain_responses();
         send_random_request();
      end
   endtask

   // Receiver: stall at random, take each response and check it
   initial begin
      int      n;
      rsp_type exp;
      while (reset) @(posedge clock);
      forever begin
         if (hold_len > 0) begin
            n        = hold_len;
            hold_len = 0;
         end else begin
            n = rsp_gaps_on ? $urandom_range(0, 15) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (rsp_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected response %p", rsp_payload);
         end else begin
            exp = rsp_due.pop_front();
            if (rsp_payload.send_grant !== exp.send_grant
                || rsp_payload.frame_seq !== exp.frame_seq
                || rsp_payload.packet_index !== exp.packet_index
                || rsp_payload.timed_out !== exp.timed_out
                || rsp_payload.transfer_done !== exp.transfer_done
                || rsp_payload.window_base !== exp.window_base) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: expected %p, got %p", exp, rsp_payload);
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[go_back_n_sender_window] ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_window_limits();
      test_zero_timeout();
      test_random_phase(140, 5, 3, 1'b1, 1'b1);
      test_random_phase(140, 40, 1, 1'b0, 1'b1);
      test_random_phase(140, 16'hFFFF, 6, 1'b0, 1'b0);
      test_random_phase(60, 0, 255, 1'b1, 1'b0);
      test_random_phase(140, $urandom_range(1, 100), $urandom_range(1, 10), 1'b1, 1'b1);
      test_random_phase(100, 17, 0, 1'b1, 1'b1);
      test_long_timeout();
      test_backpressure();
      test_random_phase(140, $urandom_range(1, 60), $urandom_range(1, 8), 1'b1, 1'b1);
      drain_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && rsp_due.size() == 0) begin
         $display("[go_back_n_sender_window] OK");
      end else begin
         $display("[go_back_n_sender_window] ERROR");
      end
      $finish;
   end

endmodule

FILE: go_back_n_sender_window.f
+incdir+sv
sv/gbn_pkg.sv
sv/gbn_csr.sv
sv/gbn_window.sv
sv/go_back_n_sender_window.sv
tb/tb_go_back_n_sender_window.sv
